FILE: rtl/core/four_state_vector_alu_defines.svh
// Assertion macros for the RTL file that carries checks.
`ifndef FOUR_STATE_VECTOR_ALU_DEFINES_SVH
`define FOUR_STATE_VECTOR_ALU_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSVA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fsva_pkg.sv
package fsva_pkg;

    localparam int IDX_W = 12;
    localparam int CNT_W = 12;
    localparam int VAL_W = 2;
    localparam int FUNC_W = 5;

    // Four-state codes.
    localparam logic [VAL_W-1:0] V0 = 2'd0;
    localparam logic [VAL_W-1:0] V1 = 2'd1;
    localparam logic [VAL_W-1:0] VX = 2'd2;
    localparam logic [VAL_W-1:0] VZ = 2'd3;

    // Number of fixed constant entries, and the compare flag locations.
    localparam int NUM_CONST = 4;
    localparam int BIT_EQ = 4;
    localparam int BIT_LT = 5;
    localparam int BIT_EEQ = 6;

    typedef enum logic [FUNC_W-1:0] {
        F_AND    = 5'd0,
        F_OR     = 5'd1,
        F_XOR    = 5'd2,
        F_XNOR   = 5'd3,
        F_INV    = 5'd4,
        F_ADD    = 5'd5,
        F_CMPS   = 5'd6,
        F_CMPU   = 5'd7,
        F_CMPX   = 5'd8,
        F_CMPZ   = 5'd9,
        F_MOV    = 5'd10,
        F_NORR   = 5'd11,
        F_LOAD   = 5'd12,
        F_EMIT   = 5'd13,
        F_JMP0   = 5'd14,
        F_JMP0XZ = 5'd15,
        F_JMP1   = 5'd16
    } t_func;

    // One classified instruction as it travels from the front to the back.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  dst;
        logic [IDX_W-1:0]  src;
        logic [CNT_W-1:0]  cnt;
        logic [VAL_W-1:0]  lval;
        logic              known;
        logic              err;
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SUM,
        S_WADD,
        S_WCMP,
        S_DONE
    } t_bstate;

    // Two-input four-state logic; op selects and, or, xor, xnor.
    function automatic logic [VAL_W-1:0] logic2(input logic [1:0] op,
                                                 input logic [VAL_W-1:0] l,
                                                 input logic [VAL_W-1:0] r);
        logic known;
        logic [VAL_W-1:0] res;
        known = !l[1] && !r[1];
        case (op)
            2'd0: begin
                if (l == V0 || r == V0) res = V0;
                else res = (l == V1 && r == V1) ? V1 : VX;
            end
            2'd1: begin
                if (l == V1 || r == V1) res = V1;
                else res = (l == V0 && r == V0) ? V0 : VX;
            end
            2'd2: res = known ? {1'b0, l[0] ^ r[0]} : VX;
            default: res = known ? {1'b0, ~(l[0] ^ r[0])} : VX;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/fsva_if.sv
// Instruction channel.
interface fsva_in_if;
    import fsva_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  dst_index;
    logic [IDX_W-1:0]  src_index;
    logic [CNT_W-1:0]  count;
    logic [VAL_W-1:0]  load_value;
    modport source (output valid, func, dst_index, src_index, count, load_value,
                    input ready);
    modport sink (input valid, func, dst_index, src_index, count, load_value,
                  output ready);
endinterface

// Result channel.
interface fsva_out_if;
    import fsva_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] out_value;
    logic             taken;
    logic             range_error;
    modport source (output valid, out_value, taken, range_error, input ready);
    modport sink (input valid, out_value, taken, range_error, output ready);
endinterface

FILE: rtl/core/fsva_front.sv
module fsva_front #(
    parameter int STORE_DEPTH = 4096,
    parameter int ADD_WIDTH = 64
) (
    fsva_in_if.sink        i_in,
    output fsva_pkg::t_op  o_op,
    output logic           o_valid,
    input  logic           i_ready
);
    import fsva_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int XW = (AW > 13) ? AW : 13;

    function automatic logic span_ok(input logic [IDX_W-1:0] base,
                                     input logic [CNT_W-1:0] n);
        logic [XW:0] b;
        logic [XW:0] last;
        b = (XW+1)'(base);
        last = b + (XW+1)'(n) - (XW+1)'(1);
        if (b >= (XW+1)'(STORE_DEPTH)) return 1'b0;
        if (n == '0 || base < IDX_W'(NUM_CONST)) return 1'b1;
        return last < (XW+1)'(STORE_DEPTH);
    endfunction

    logic w_dst_low;
    logic w_dok;
    logic w_sok;
    logic w_dok1;
    logic w_sok1;

    assign w_dst_low = i_in.dst_index < IDX_W'(NUM_CONST);
    assign w_dok = span_ok(i_in.dst_index, i_in.count);
    assign w_sok = span_ok(i_in.src_index, i_in.count);
    assign w_dok1 = span_ok(i_in.dst_index, CNT_W'(1));
    assign w_sok1 = span_ok(i_in.src_index, CNT_W'(1));

    always_comb begin
        o_op.func = i_in.func;
        o_op.dst = i_in.dst_index;
        o_op.src = i_in.src_index;
        o_op.cnt = i_in.count;
        o_op.lval = i_in.load_value;
        o_op.known = 1'b1;
        o_op.err = 1'b0;
        case (i_in.func)
            F_AND, F_OR, F_XOR, F_XNOR, F_MOV: o_op.err = w_dst_low || !w_dok || !w_sok;
            F_INV: o_op.err = w_dst_low || !w_dok;
            F_ADD: o_op.err = w_dst_low || !w_dok || !w_sok ||
                              (i_in.count > CNT_W'(ADD_WIDTH));
            F_CMPS, F_CMPU, F_CMPX, F_CMPZ: o_op.err = !w_dok || !w_sok;
            F_NORR: o_op.err = w_dst_low || !w_dok1 || !w_sok;
            F_LOAD: o_op.err = w_dst_low || !w_dok1;
            F_EMIT, F_JMP0, F_JMP0XZ, F_JMP1: o_op.err = !w_sok1;
            default: o_op.known = 1'b0;
        endcase
    end

    assign o_valid = i_in.valid;
    assign i_in.ready = i_ready;

endmodule

FILE: rtl/core/fsva_queue.sv
module fsva_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fsva_pkg::t_op  i_op,
    input  logic           i_push,
    output logic           o_not_full,
    output fsva_pkg::t_op  o_op,
    output logic           o_not_empty,
    input  logic           i_pop
);
    import fsva_pkg::*;

    t_op        r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_not_full = r_cnt != 2'd2;
    assign o_not_empty = r_cnt != 2'd0;
    assign o_op = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && o_not_full) begin
            r_slot[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && o_not_full) r_wp <= ~r_wp;
            if (i_pop && o_not_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && o_not_full) ? 1 : 0)
                           - 2'((i_pop && o_not_empty) ? 1 : 0);
        end
    end

endmodule

FILE: rtl/core/fsva_back.sv
module fsva_back #(
    parameter int STORE_DEPTH = 4096,
    parameter int ADD_WIDTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fsva_pkg::t_op  i_op,
    input  logic           i_valid,
    output logic           o_pop,
    fsva_out_if.source     o_out
);
    import fsva_pkg::*;
    `include "four_state_vector_alu_defines.svh"

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int XW = (AW > 13) ? AW : 13;
    localparam int SW = $clog2(ADD_WIDTH);

    logic [VAL_W-1:0] r_mem [STORE_DEPTH];
    logic [VAL_W-1:0] r_rd_l;
    logic [VAL_W-1:0] r_rd_r;

    t_bstate r_state, n_state;
    t_op     r_op, n_op;
    logic [CNT_W:0]   r_i, n_i;
    logic [AW-1:0]    r_clr, n_clr;
    logic [1:0]       r_wc, n_wc;
    logic [VAL_W-1:0] r_eq, n_eq;
    logic [VAL_W-1:0] r_lt, n_lt;
    logic             r_eeq, n_eeq;
    logic [VAL_W-1:0] r_s1, n_s1;
    logic [VAL_W-1:0] r_s2, n_s2;
    logic [VAL_W-1:0] r_res, n_res;
    logic             r_unk, n_unk;
    logic [ADD_WIDTH-1:0] r_lv, n_lv;
    logic [ADD_WIDTH-1:0] r_rv, n_rv;
    logic [ADD_WIDTH-1:0] r_sum, n_sum;
    logic [VAL_W-1:0] r_ov, n_ov;
    logic             r_tk, n_tk;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic             r_out_taken, n_out_taken;
    logic             r_out_err, n_out_err;

    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [VAL_W-1:0] w_wd;
    logic             w_re;
    logic [AW-1:0]    w_ra_l;
    logic [AW-1:0]    w_ra_r;
    logic [VAL_W-1:0] w_l;
    logic [VAL_W-1:0] w_r;
    logic [VAL_W-1:0] w_lt_fin;
    logic [XW-1:0]    w_dsum;
    logic [XW-1:0]    w_ssum;
    logic             w_last;
    logic             w_out_free;
    logic [VAL_W-1:0] w_e;
    t_bstate          w_tail;

    assign w_dsum = XW'(r_op.dst) + XW'(r_i);
    assign w_ssum = XW'(r_op.src) + XW'(r_i);
    assign w_ra_l = w_dsum[AW-1:0];
    assign w_ra_r = (r_op.src < IDX_W'(NUM_CONST)) ? AW'(r_op.src) : w_ssum[AW-1:0];
    assign w_l = (r_op.dst < IDX_W'(NUM_CONST)) ? r_op.dst[VAL_W-1:0] : r_rd_l;
    assign w_r = (r_op.src < IDX_W'(NUM_CONST)) ? r_op.src[VAL_W-1:0] : r_rd_r;
    assign w_last = (r_i + (CNT_W+1)'(1)) >= (CNT_W+1)'(r_op.cnt);
    assign w_out_free = !r_out_valid || o_out.ready;

    // Signed compares let the top operand bits decide when no x or z was seen.
    always_comb begin
        w_lt_fin = r_lt;
        if (r_eq == VX) begin
            w_lt_fin = VX;
        end else if (r_op.func == F_CMPS && r_op.cnt != '0) begin
            if (r_s1 == V1 && r_s2 == V0) w_lt_fin = V1;
            else if (r_s1 == V0 && r_s2 == V1) w_lt_fin = V0;
        end
    end

    // Where a walk ends, or an empty span lands directly.
    always_comb begin
        case (r_op.func)
            F_CMPS, F_CMPU, F_CMPX, F_CMPZ, F_NORR: w_tail = S_WCMP;
            F_ADD: w_tail = S_SUM;
            default: w_tail = S_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) begin
            r_rd_l <= r_mem[w_ra_l];
            r_rd_r <= r_mem[w_ra_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_i <= n_i;
        r_wc <= n_wc;
        r_eq <= n_eq;
        r_lt <= n_lt;
        r_eeq <= n_eeq;
        r_s1 <= n_s1;
        r_s2 <= n_s2;
        r_res <= n_res;
        r_unk <= n_unk;
        r_lv <= n_lv;
        r_rv <= n_rv;
        r_sum <= n_sum;
        r_ov <= n_ov;
        r_tk <= n_tk;
        r_out_value <= n_out_value;
        r_out_taken <= n_out_taken;
        r_out_err <= n_out_err;
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_i = r_i;
        n_clr = r_clr;
        n_wc = r_wc;
        n_eq = r_eq;
        n_lt = r_lt;
        n_eeq = r_eeq;
        n_s1 = r_s1;
        n_s2 = r_s2;
        n_res = r_res;
        n_unk = r_unk;
        n_lv = r_lv;
        n_rv = r_rv;
        n_sum = r_sum;
        n_ov = r_ov;
        n_tk = r_tk;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_value = r_out_value;
        n_out_taken = r_out_taken;
        n_out_err = r_out_err;
        o_pop = 1'b0;
        w_we = 1'b0;
        w_wa = w_ra_l;
        w_wd = VX;
        w_re = 1'b0;
        w_e = r_eq;

        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_clr;
                w_wd = VX;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(STORE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_op = i_op;
                    n_i = '0;
                    n_wc = '0;
                    n_eq = V1;
                    n_lt = V0;
                    n_eeq = 1'b1;
                    n_s1 = V0;
                    n_s2 = V0;
                    n_res = V1;
                    n_unk = 1'b0;
                    n_lv = '0;
                    n_rv = '0;
                    n_ov = V0;
                    n_tk = 1'b0;
                    if (i_op.err || !i_op.known) begin
                        n_state = S_DONE;
                    end else if (i_op.func == F_LOAD) begin
                        w_we = 1'b1;
                        w_wa = AW'(i_op.dst);
                        w_wd = i_op.lval;
                        n_state = S_DONE;
                    end else if (i_op.func inside {F_EMIT, F_JMP0, F_JMP0XZ, F_JMP1}) begin
                        n_state = S_READ;
                    end else if (i_op.cnt == '0) begin
                        case (i_op.func)
                            F_CMPS, F_CMPU, F_CMPX, F_CMPZ, F_NORR: n_state = S_WCMP;
                            default: n_state = S_DONE;
                        endcase
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                w_re = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_i = r_i + (CNT_W+1)'(1);
                n_state = w_last ? w_tail : S_READ;
                case (r_op.func)
                    F_AND, F_OR, F_XOR, F_XNOR: begin
                        w_we = 1'b1;
                        w_wd = logic2(r_op.func[1:0], w_l, w_r);
                    end
                    F_INV: begin
                        w_we = 1'b1;
                        w_wd = (w_l == V0) ? V1 : ((w_l == V1) ? V0 : VX);
                    end
                    F_MOV: begin
                        w_we = 1'b1;
                        w_wd = w_r;
                    end
                    F_ADD: begin
                        if (w_l[1] || w_r[1]) begin
                            n_unk = 1'b1;
                        end else begin
                            n_lv[r_i[SW-1:0]] = w_l[0];
                            n_rv[r_i[SW-1:0]] = w_r[0];
                        end
                    end
                    F_CMPS, F_CMPU: begin
                        if (w_l > w_r) begin
                            n_lt = V0;
                            n_eeq = 1'b0;
                        end else if (w_l < w_r) begin
                            n_lt = V1;
                            n_eeq = 1'b0;
                        end
                        if (r_eq != VX) begin
                            if (w_l == V0 && w_r != V0) w_e = V0;
                            if (w_l == V1 && w_r != V1) w_e = V0;
                            if (w_l[1] || w_r[1]) w_e = VX;
                            n_eq = w_e;
                        end
                        n_s1 = w_l;
                        n_s2 = w_r;
                    end
                    F_CMPX: begin
                        if (!w_l[1] && !w_r[1] && w_l != w_r) n_eq = V0;
                    end
                    F_CMPZ: begin
                        if (w_l != VZ && w_r != VZ && w_l != w_r) n_eq = V0;
                    end
                    F_NORR: begin
                        if (r_res != V0) begin
                            if (w_r == V1) n_res = V0;
                            else if (w_r != V0) n_res = VX;
                        end
                    end
                    F_EMIT: begin
                        n_ov = w_r;
                        n_state = S_DONE;
                    end
                    F_JMP0: begin
                        n_tk = w_r == V0;
                        n_state = S_DONE;
                    end
                    F_JMP0XZ: begin
                        n_tk = w_r != V1;
                        n_state = S_DONE;
                    end
                    F_JMP1: begin
                        n_tk = w_r == V1;
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SUM: begin
                n_sum = r_lv + r_rv;
                n_i = '0;
                n_state = S_WADD;
            end
            S_WADD: begin
                w_we = 1'b1;
                w_wd = r_unk ? VX : {1'b0, r_sum[r_i[SW-1:0]]};
                n_i = r_i + (CNT_W+1)'(1);
                if (w_last) n_state = S_DONE;
            end
            S_WCMP: begin
                w_we = 1'b1;
                n_wc = r_wc + 2'd1;
                if (r_op.func == F_NORR) begin
                    w_wa = AW'(r_op.dst);
                    w_wd = r_res;
                    n_state = S_DONE;
                end else if (r_op.func inside {F_CMPX, F_CMPZ} || r_wc == 2'd0) begin
                    w_wa = AW'(BIT_EQ);
                    w_wd = r_eq;
                    if (r_op.func inside {F_CMPX, F_CMPZ}) n_state = S_DONE;
                end else if (r_wc == 2'd1) begin
                    w_wa = AW'(BIT_LT);
                    w_wd = w_lt_fin;
                end else begin
                    w_wa = AW'(BIT_EEQ);
                    w_wd = {1'b0, r_eeq};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_ov;
                    n_out_taken = r_tk;
                    n_out_err = r_op.err;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.taken = r_out_taken;
    assign o_out.range_error = r_out_err;

    `FSVA_ASSERT_NOW(a_no_pop_in_clear, r_state == S_CLEAR, !o_pop, "pop during clear pass")
    `FSVA_ASSERT_NOW(a_const_protected, w_we && r_state != S_CLEAR,
                     w_wa >= AW'(NUM_CONST), "write to a constant entry")
    `FSVA_ASSERT_NEXT(a_done_delivers, r_state == S_DONE && w_out_free,
                      r_out_valid && r_state == S_IDLE, "result not registered")

endmodule

FILE: rtl/core/four_state_vector_alu.sv
// Channel   Direction  Beat contents
// i_in      sink       func, dst_index, src_index, count, load_value
// o_out     source     out_value, taken, range_error
//
// After reset the store is swept to x, one entry a cycle.
// A vector operation walks its span bit by bit: each bit is read, then executed and written.
// Signed and unsigned compares add three flag writes at the end, x and z compares one.
// A two-beat queue parts the front from the execution engine; while it has room, beats are
// taken during the sweep, while an instruction runs or while a result waits for o_out.ready.
module four_state_vector_alu #(
    parameter int STORE_DEPTH = 4096,
    parameter int ADD_WIDTH = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    fsva_in_if.sink    i_in,
    fsva_out_if.source o_out
);
    import fsva_pkg::*;

    // Front classifies each beat and flags refused accesses up front.
    t_op  w_f_op;
    logic w_f_valid;
    logic w_q_not_full;
    t_op  w_q_op;
    logic w_q_not_empty;
    logic w_pop;

    fsva_front #(
        .STORE_DEPTH(STORE_DEPTH),
        .ADD_WIDTH(ADD_WIDTH)
    ) u_front (
        .i_in(i_in),
        .o_op(w_f_op),
        .o_valid(w_f_valid),
        .i_ready(w_q_not_full)
    );

    // The queue lets input and execution stall independently.
    fsva_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_op(w_f_op),
        .i_push(w_f_valid),
        .o_not_full(w_q_not_full),
        .o_op(w_q_op),
        .o_not_empty(w_q_not_empty),
        .i_pop(w_pop)
    );

    // The back walks the span bit by bit on the store and registers the result.
    fsva_back #(
        .STORE_DEPTH(STORE_DEPTH),
        .ADD_WIDTH(ADD_WIDTH)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_op(w_q_op),
        .i_valid(w_q_not_empty),
        .o_pop(w_pop),
        .o_out(o_out)
    );

endmodule
